@@ rtl/rotary_encoder_button_decoder_assert.svh @@
// Assertion helpers shared by the decoder modules.
`ifndef ROTARY_ENCODER_BUTTON_DECODER_ASSERT_SVH
`define ROTARY_ENCODER_BUTTON_DECODER_ASSERT_SVH

// Plain property, checked on every clock outside reset.
`define RED_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next cycle.
`define RED_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/red_pkg.sv @@
package red_pkg;

  // Register widths and reset values
  localparam int HOLD_W = 16;
  localparam logic [HOLD_W-1:0] HOLD_TICKS_RESET = 16'd250;
  localparam logic [HOLD_W-1:0] HOLD_COUNT_MAX = 16'hFFFF;
  localparam int CFG_DATA_W = HOLD_W;

  // Register indexes on the write port
  typedef enum logic {
    REG_HOLD_TICKS     = 1'b0,
    REG_BUTTON_ENABLED = 1'b1
  } reg_index_t;

  // Event codes on the result channel
  typedef enum logic [1:0] {
    EV_RIGHT   = 2'd0,
    EV_LEFT    = 2'd1,
    EV_PRESSED = 2'd2,
    EV_HELD    = 2'd3
  } event_t;

  // Last channel that produced an accepted edge
  typedef enum logic [1:0] {
    CH_NONE = 2'd0,
    CH_A    = 2'd1,
    CH_B    = 2'd2
  } channel_t;

  // Events of one tick: slot 0 right, slot 1 left, slot 2 button
  typedef struct packed {
    logic [2:0] mask;
    logic       held;
  } tick_events_t;

endpackage

@@ rtl/red_step.sv @@
module red_step import red_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  logic              level_a,
  input  logic              level_b,
  input  logic              level_push,
  input  logic [HOLD_W-1:0] hold_ticks,
  input  logic              button_enabled,
  output tick_events_t      events
);

  // Decoder state
  logic              prev_a, prev_a_next;
  logic              prev_b, prev_b_next;
  logic              prev_push, prev_push_next;
  channel_t          last_channel, last_channel_next;
  logic [HOLD_W-1:0] hold_count, hold_count_next;
  logic              hold_active, hold_active_next;
  logic              hold_fired, hold_fired_next;

  logic              a_take, b_take;
  channel_t          last_mid;
  logic              push_chg, press_now, release_now;
  logic              pressed_ev, held_ev, count_en;
  logic [HOLD_W-1:0] count_mid, count_inc;

  // Channel A then channel B, each ignored if it changed last
  always_comb begin
    a_take      = (level_a != prev_a) && (last_channel != CH_A);
    last_mid    = a_take ? CH_A : last_channel;
    b_take      = (level_b != prev_b) && (last_mid != CH_B);
    prev_a_next = level_a;
    prev_b_next = level_b;
    last_channel_next = b_take ? CH_B : last_mid;
  end

  // Button press, release and hold counting
  always_comb begin
    push_chg    = button_enabled && (level_push != prev_push);
    press_now   = push_chg && prev_push;
    release_now = push_chg && !prev_push;
    prev_push_next   = push_chg ? level_push : prev_push;
    hold_active_next = press_now ? 1'b1 : (release_now ? 1'b0 : hold_active);
    count_mid        = press_now ? '0 : hold_count;
    hold_fired_next  = press_now ? 1'b0 : hold_fired;
    pressed_ev       = release_now && !hold_fired;

    count_en  = button_enabled && !press_now && hold_active_next && !hold_fired_next
                && !prev_push_next;
    count_inc = (count_mid == HOLD_COUNT_MAX) ? count_mid : count_mid + HOLD_W'(1);
    hold_count_next = count_en ? count_inc : count_mid;
    held_ev   = count_en && (count_inc >= hold_ticks);
    if (held_ev) begin
      hold_fired_next = 1'b1;
    end

    events.mask[0] = a_take && level_a && prev_b;
    events.mask[1] = b_take && level_b && level_a;
    events.mask[2] = pressed_ev || held_ev;
    events.held    = held_ev;
  end

  // State advances once per accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_a       <= 1'b1;
      prev_b       <= 1'b1;
      prev_push    <= 1'b1;
      last_channel <= CH_NONE;
      hold_count   <= '0;
      hold_active  <= 1'b0;
      hold_fired   <= 1'b0;
    end else if (load) begin
      prev_a       <= prev_a_next;
      prev_b       <= prev_b_next;
      prev_push    <= prev_push_next;
      last_channel <= last_channel_next;
      hold_count   <= hold_count_next;
      hold_active  <= hold_active_next;
      hold_fired   <= hold_fired_next;
    end
  end

`include "rotary_encoder_button_decoder_assert.svh"

  // Held only while the button is down; it latches the fired flag
  `RED_ASSERT(a_held_down, !(load && events.held) || !level_push, "held with button up")
  `RED_ASSERT_NEXT(a_held_once, load && events.held, hold_fired, "held did not latch")
  // A press event only comes from a release
  `RED_ASSERT(a_press_up, !(load && events.mask[2] && !events.held) || (level_push && !prev_push),
              "pressed without release")

endmodule

@@ rtl/red_evbuf.sv @@
module red_evbuf import red_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  tick_events_t events,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [1:0]   event_code,
  output logic         last_of_tick
);

  logic [2:0] mask, mask_next, mask_rest;
  logic       held;
  logic       load, out_fire;

  // Remaining events of the current tick, lowest slot first
  always_comb begin
    mask_rest    = mask & (mask - 3'd1);
    out_valid    = |mask;
    out_fire     = out_valid && out_ready;
    last_of_tick = (mask_rest == 3'd0);
    in_ready     = !out_valid || (last_of_tick && out_ready);
    load         = in_valid && in_ready;
    if (mask[0]) begin
      event_code = EV_RIGHT;
    end else if (mask[1]) begin
      event_code = EV_LEFT;
    end else if (held) begin
      event_code = EV_HELD;
    end else begin
      event_code = EV_PRESSED;
    end
    if (load) begin
      mask_next = events.mask;
    end else if (out_fire) begin
      mask_next = mask_rest;
    end else begin
      mask_next = mask;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else begin
      mask <= mask_next;
    end
  end

  // Button code travels with the mask
  always_ff @(posedge clk) begin
    if (load) begin
      held <= events.held;
    end
  end

`include "rotary_encoder_button_decoder_assert.svh"

  // Pending events hold while stalled and drop one per delivered request
  `RED_ASSERT_NEXT(a_stall_hold, !load && !out_fire, mask == $past(mask), "events lost")
  `RED_ASSERT_NEXT(a_one_out, out_fire && !load,
                   $countones(mask) == $countones($past(mask)) - 1, "event count slip")

endmodule

@@ rtl/rotary_encoder_button_decoder.sv @@
// Rotary encoder and push button decoder.
// Input channel (in_valid/in_ready): one request per poll tick carrying the
// sampled levels level_a, level_b and level_push (0 = pressed).
// Output channel (out_valid/out_ready): zero to two events per tick, in the
// order A edge, B edge, button; last_of_tick marks the final event of a tick.
// Codes: 0 turn right, 1 turn left, 2 pressed, 3 held.
// Config: write_enable/write_index/write_data; index 0 hold_ticks,
// index 1 button_enabled (bit 0). Write only while idle.
// Latency: events of a tick appear the cycle after it is accepted.
// Throughput: one tick per cycle unless stalled; a tick with events holds the output
// register until its last event has left, and the next tick is taken in the cycle its last
// event leaves. Ticks with no events need only an empty output register.
// A stalled receiver holds the current event; the input then waits.
// Reset: pins read as high/released, no last channel, hold logic idle,
// hold_ticks 250 and the button enabled.
module rotary_encoder_button_decoder import red_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  level_a,
  input  logic                  level_b,
  input  logic                  level_push,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            event_code,
  output logic                  last_of_tick,
  input  logic                  write_enable,
  input  logic                  write_index,
  input  logic [CFG_DATA_W-1:0] write_data
);

  logic [HOLD_W-1:0] hold_ticks;
  logic              button_enabled;
  tick_events_t      events;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_ticks     <= HOLD_TICKS_RESET;
      button_enabled <= 1'b1;
    end else if (write_enable) begin
      case (write_index)
        REG_HOLD_TICKS:     hold_ticks     <= write_data[HOLD_W-1:0];
        REG_BUTTON_ENABLED: button_enabled <= write_data[0];
        default: ;
      endcase
    end
  end

  red_step u_step (
    .clk            (clk),
    .rst            (rst),
    .load           (in_valid && in_ready),
    .level_a        (level_a),
    .level_b        (level_b),
    .level_push     (level_push),
    .hold_ticks     (hold_ticks),
    .button_enabled (button_enabled),
    .events         (events)
  );

  red_evbuf u_evbuf (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .events       (events),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .event_code   (event_code),
    .last_of_tick (last_of_tick)
  );

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import red_pkg::*;

  // One decoded event as the block should report it
  typedef struct {
    event_t code;
    logic   last;
  } tick_event_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  level_a = 1'b1;
  logic                  level_b = 1'b1;
  logic                  level_push = 1'b1;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [1:0]            event_code;
  logic                  last_of_tick;
  logic                  write_enable = 1'b0;
  reg_index_t            write_index = REG_HOLD_TICKS;
  logic [CFG_DATA_W-1:0] write_data = '0;

  rotary_encoder_button_decoder dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .level_a      (level_a),
    .level_b      (level_b),
    .level_push   (level_push),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .event_code   (event_code),
    .last_of_tick (last_of_tick),
    .write_enable (write_enable),
    .write_index  (write_index),
    .write_data   (write_data)
  );

  always #6 clk = ~clk;

  // Decoder state mirrored by the testbench
  logic              pin_a = 1'b1;
  logic              pin_b = 1'b1;
  logic              pin_push = 1'b1;
  channel_t          last_ch = CH_NONE;
  logic [HOLD_W-1:0] hold_cnt = '0;
  logic              hold_on = 1'b0;
  logic              hold_done = 1'b0;
  logic [HOLD_W-1:0] hold_limit = HOLD_TICKS_RESET;
  logic              btn_en = 1'b1;

  tick_event_t pending_events[$];

  // Levels currently driven and sender burst state
  logic drv_a = 1'b1;
  logic drv_b = 1'b1;
  logic drv_p = 1'b1;
  int   burst_left = 0;
  bit   no_gaps = 1'b0;
  bit   turn_up = 1'b1;
  int   press_len = 0;
  int   press_target = 0;

  // Quadrature positions; stepping forward is a right turn
  logic [1:0] quad_pos [4] = '{2'b11, 2'b10, 2'b00, 2'b01};

  int ticks_sent = 0;
  int events_checked = 0;
  int seen_by_code [4] = '{0, 0, 0, 0};
  int mismatches = 0;

  // Receiver stall control
  logic     hold_off = 1'b0;
  int       hold_off_len = 0;
  int unsigned ready_cyc = 0;
  event     hold_off_kick;

  // Work out the events of one accepted tick and queue them
  function automatic void decode_tick(logic a, logic b, logic p);
    event_t evs[$];
    logic   press_now = 1'b0;
    tick_event_t ev;
    if (a != pin_a) begin
      pin_a = a;
      if (last_ch != CH_A) begin
        last_ch = CH_A;
        if (a && pin_b) evs.push_back(EV_RIGHT);
      end
    end
    if (b != pin_b) begin
      pin_b = b;
      if (last_ch != CH_B) begin
        last_ch = CH_B;
        if (b && pin_a) evs.push_back(EV_LEFT);
      end
    end
    if (btn_en) begin
      if (p != pin_push) begin
        if (pin_push) begin
          pin_push = 1'b0;
          hold_on = 1'b1;
          hold_cnt = '0;
          hold_done = 1'b0;
          press_now = 1'b1;
        end else begin
          pin_push = 1'b1;
          hold_on = 1'b0;
          if (!hold_done) evs.push_back(EV_PRESSED);
        end
      end
      // count ticks after the press tick, fire held once
      if (!press_now && hold_on && !hold_done && !pin_push) begin
        if (hold_cnt != HOLD_COUNT_MAX) hold_cnt = hold_cnt + HOLD_W'(1);
        if (hold_cnt >= hold_limit) begin
          hold_done = 1'b1;
          evs.push_back(EV_HELD);
        end
      end
    end
    foreach (evs[i]) begin
      ev.code = evs[i];
      ev.last = (i == evs.size() - 1);
      pending_events.push_back(ev);
    end
  endfunction

  function automatic void note_mismatch(string what);
    mismatches++;
    if (mismatches <= 10) $display("%0t: mismatch: %s", $realtime, what);
  endfunction

  // Send one tick request; the sender may idle between bursts
  task automatic send_tick(logic a, logic b, logic p);
    int gap = 0;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    @(negedge clk);
    if (gap > 0 && !no_gaps) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    level_a <= a;
    level_b <= b;
    level_push <= p;
    drv_a = a;
    drv_b = b;
    drv_p = p;
    do @(posedge clk); while (!in_ready);
    decode_tick(a, b, p);
    ticks_sent++;
  endtask

  // Stop sending and wait for every queued event, plus a little latency
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    write_enable <= 1'b1;
    write_index <= idx;
    write_data <= val;
    @(negedge clk);
    write_enable <= 1'b0;
    case (idx)
      REG_HOLD_TICKS:     hold_limit = val;
      REG_BUTTON_ENABLED: btn_en = val[0];
      default: ;
    endcase
  endtask

  // Keep the button down for n ticks, encoder pins unchanged
  task automatic keep_pressed(int n);
    repeat (n) send_tick(drv_a, drv_b, 1'b0);
  endtask

  // Directed encoder sequences: both directions, bounce, twin edges
  task automatic test_turns();
    send_tick(1'b1, 1'b0, 1'b1);
    send_tick(1'b0, 1'b0, 1'b1);
    send_tick(1'b0, 1'b1, 1'b1);
    send_tick(1'b1, 1'b1, 1'b1);   // right
    send_tick(1'b0, 1'b1, 1'b1);
    send_tick(1'b0, 1'b0, 1'b1);
    send_tick(1'b1, 1'b0, 1'b1);
    send_tick(1'b1, 1'b1, 1'b1);   // left
    send_tick(1'b0, 1'b1, 1'b1);   // A bounce
    send_tick(1'b1, 1'b1, 1'b1);
    send_tick(1'b0, 1'b1, 1'b1);
    send_tick(1'b0, 1'b0, 1'b1);   // B bounce
    send_tick(1'b0, 1'b1, 1'b1);
    send_tick(1'b0, 1'b0, 1'b1);
    send_tick(1'b1, 1'b1, 1'b1);   // both pins in one tick
    send_tick(1'b0, 1'b0, 1'b1);
    send_tick(1'b1, 1'b0, 1'b1);
    send_tick(1'b0, 1'b0, 1'b1);
    send_tick(1'b0, 1'b1, 1'b0);   // press
    send_tick(1'b1, 1'b1, 1'b1);   // right and pressed in one tick
    drain();
  endtask

  // Button timing, zero hold, disable while pressed
  task automatic test_button();
    write_reg(REG_HOLD_TICKS, 16'd0);
    send_tick(drv_a, drv_b, 1'b0);
    keep_pressed(2);                 // held on the first tick after press
    send_tick(drv_a, drv_b, 1'b1);   // release after held: quiet
    send_tick(drv_a, drv_b, 1'b0);
    send_tick(drv_a, drv_b, 1'b1);   // press and release next tick
    drain();
    write_reg(REG_HOLD_TICKS, 16'd1);
    send_tick(drv_a, drv_b, 1'b0);
    send_tick(drv_a, drv_b, 1'b1);   // released before count: pressed
    send_tick(1'b1, 1'b0, 1'b1);
    send_tick(1'b0, 1'b0, 1'b1);
    send_tick(1'b1, 1'b0, 1'b0);
    send_tick(1'b1, 1'b1, 1'b0);     // left and held in one tick
    send_tick(1'b1, 1'b1, 1'b1);
    drain();
    // disabled button keeps its state across the gap
    write_reg(REG_HOLD_TICKS, 16'd3);
    send_tick(drv_a, drv_b, 1'b0);
    keep_pressed(1);
    drain();
    write_reg(REG_BUTTON_ENABLED, 16'd0);
    send_tick(drv_a, drv_b, 1'b1);
    send_tick(drv_a, drv_b, 1'b0);
    send_tick(1'b0, 1'b1, 1'b1);
    send_tick(1'b0, 1'b0, 1'b0);
    send_tick(1'b0, 1'b1, 1'b1);
    send_tick(1'b1, 1'b1, 1'b0);
    drain();
    write_reg(REG_BUTTON_ENABLED, 16'd1);
    keep_pressed(3);
    send_tick(drv_a, drv_b, 1'b1);
    drain();
  endtask

  // Hold detection at a longer count, quiet ticks after held
  task automatic test_hold_limits();
    no_gaps = 1'b1;
    write_reg(REG_HOLD_TICKS, 16'd12);
    send_tick(drv_a, drv_b, 1'b0);
    keep_pressed(13);
    send_tick(drv_a, drv_b, 1'b1);
    drain();
    no_gaps = 1'b0;
  endtask

  // Long receiver stall while requests keep coming
  task automatic test_backpressure();
    logic [1:0] ab;
    write_reg(REG_HOLD_TICKS, 16'd1000);
    -> hold_off_kick;
    for (int i = 0; i < 32; i++) begin
      ab = quad_pos[(i / 2) % 4];
      send_tick(ab[1], ab[0], i[0]);
    end
    drain();
  endtask

  // Random ticks: mostly clean quadrature steps and press runs, some noise
  task automatic random_ticks(int count);
    int   idx;
    int   r;
    int   cap;
    logic a;
    logic b;
    logic p;
    for (int i = 0; i < count; i++) begin
      a = drv_a;
      b = drv_b;
      p = drv_p;
      r = $urandom_range(0, 99);
      if (r < 70) begin
        if ($urandom_range(0, 7) == 0) turn_up = ~turn_up;
        idx = 0;
        foreach (quad_pos[k]) if (quad_pos[k] == {drv_a, drv_b}) idx = k;
        idx = (idx + (turn_up ? 1 : 3)) % 4;
        {a, b} = quad_pos[idx];
      end else if (r >= 85) begin
        a = 1'($urandom_range(0, 1));
        b = 1'($urandom_range(0, 1));
      end
      if ($urandom_range(0, 19) == 0) begin
        p = 1'($urandom_range(0, 1));
      end else if (drv_p) begin
        if ($urandom_range(0, 4) == 0) begin
          p = 1'b0;
          press_len = 0;
          cap = (hold_limit > 12) ? 12 : hold_limit;
          press_target = $urandom_range(0, cap + 3);
        end
      end else begin
        press_len++;
        if (press_len > press_target) p = 1'b1;
      end
      send_tick(a, b, p);
    end
  endtask

  task automatic test_random();
    logic [HOLD_W-1:0] holds [5] = '{16'd2, 16'd0, 16'd4, 16'd1, 16'd7};
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(REG_HOLD_TICKS, holds[ph]);
      write_reg(REG_BUTTON_ENABLED, (ph == 2) ? 16'd0 : 16'd1);
      random_ticks(8);
      drain();
    end
  endtask

  // Receiver: rotating stall patterns, overridden by a long hold-off
  always @(negedge clk) begin
    logic rdy;
    ready_cyc++;
    case (ready_cyc[7:6])
      2'd0: rdy = 1'b1;
      2'd1: rdy = ($urandom_range(0, 3) != 0);
      2'd2: rdy = ($urandom_range(0, 9) < 3);
      default: rdy = ((ready_cyc % 5) != 0);
    endcase
    out_ready <= hold_off ? 1'b0 : rdy;
  end

  // Long hold-off, counted in cycles
  always begin
    @(hold_off_kick);
    @(posedge clk);
    hold_off <= 1'b1;
    hold_off_len = 0;
    while (hold_off_len < 120) begin
      @(posedge clk);
      hold_off_len++;
    end
    hold_off <= 1'b0;
  end

  // Compare each delivered event with the oldest expectation
  always @(posedge clk) begin
    tick_event_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_events.size() == 0) begin
        note_mismatch($sformatf("unexpected event code %0d last %0b",
                                event_code, last_of_tick));
      end else begin
        want = pending_events.pop_front();
        events_checked++;
        seen_by_code[want.code]++;
        if (event_code !== want.code || last_of_tick !== want.last)
          note_mismatch($sformatf("expected code %0d last %0b, got code %0d last %0b",
                                  want.code, want.last, event_code, last_of_tick));
      end
    end
  end

  initial begin
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    test_turns();
    test_button();
    test_hold_limits();
    test_backpressure();
    test_random();
    drain();
    if (pending_events.size() != 0)
      note_mismatch($sformatf("%0d events never delivered", pending_events.size()));
    $display("Sent %0d poll ticks; checked %0d events: %0d right, %0d left, %0d pressed, %0d held",
             ticks_sent, events_checked, seen_by_code[EV_RIGHT], seen_by_code[EV_LEFT],
             seen_by_code[EV_PRESSED], seen_by_code[EV_HELD]);
    $display("Hold counts 0, 1, 3, 12 and random, button on and off, long output stall; %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #1_000_000;
    $display("Timeout with %0d events outstanding", pending_events.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/red_pkg.sv
rtl/red_step.sv
rtl/red_evbuf.sv
rtl/rotary_encoder_button_decoder.sv
bench/tb.sv
